>>> sv/amo_pkg.sv
// Shared types, sizes and operation codes for the atomic memory operation unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package amo_pkg;

  localparam int WORDS  = 1024;            // store depth, a power of two
  localparam int IDX_W  = $clog2(WORDS);
  localparam int FUNC_W = 4;
  localparam int ADDR_W = 10;
  localparam int DATA_W = 64;
  localparam int REG_W  = 5;

  localparam logic [FUNC_W-1:0] OP_LR   = 4'd0;
  localparam logic [FUNC_W-1:0] OP_SC   = 4'd1;
  localparam logic [FUNC_W-1:0] OP_SWAP = 4'd2;
  localparam logic [FUNC_W-1:0] OP_ADD  = 4'd3;
  localparam logic [FUNC_W-1:0] OP_XOR  = 4'd4;
  localparam logic [FUNC_W-1:0] OP_AND  = 4'd5;
  localparam logic [FUNC_W-1:0] OP_OR   = 4'd6;
  localparam logic [FUNC_W-1:0] OP_MIN  = 4'd7;
  localparam logic [FUNC_W-1:0] OP_MAX  = 4'd8;
  localparam logic [FUNC_W-1:0] OP_MINU = 4'd9;
  localparam logic [FUNC_W-1:0] OP_MAXU = 4'd10;

  // controller -> datapath
  typedef struct packed {
    logic             accept;     // capture input word, read store
    logic             exec;       // compute, write back, load result
    logic             clear_we;   // clearing pass write
    logic [IDX_W-1:0] clear_idx;
  } amo_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;               // result register can take a word this cycle
  } amo_sts_t;

  // address wraps onto the store
  function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_W-1:0] address);
    return IDX_W'(address % WORDS);
  endfunction

endpackage

>>> sv/amo_ctrl.sv
// Sequencer of the atomic memory operation unit: clearing pass, accept, execute.
// Depends on amo_pkg.
`timescale 1ns / 1ps

module amo_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  amo_pkg::amo_sts_t sts,
  output amo_pkg::amo_cmd_t cmd
);
  import amo_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] clear_cnt;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clear_cnt == IDX_W'(WORDS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clear_cnt <= clear_cnt + 1'b1;
    end
  end

  assign in_stall      = (state != S_IDLE);
  assign cmd.accept    = (state == S_IDLE) && in_valid;
  assign cmd.exec      = (state == S_EXEC) && sts.out_free;
  assign cmd.clear_we  = (state == S_CLEAR);
  assign cmd.clear_idx = clear_cnt;

endmodule

>>> sv/amo_datapath.sv
// Datapath: word store, reservation, operation ALU and result register.
// Depends on amo_pkg; driven by amo_ctrl commands.
`timescale 1ns / 1ps

module amo_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  amo_pkg::amo_cmd_t           cmd,
  output amo_pkg::amo_sts_t           sts,
  input  logic [amo_pkg::FUNC_W-1:0]  func,
  input  logic [amo_pkg::ADDR_W-1:0]  address,
  input  logic [amo_pkg::DATA_W-1:0]  operand,
  input  logic [amo_pkg::REG_W-1:0]   dest_reg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [amo_pkg::REG_W-1:0]   dest_out,
  output logic [amo_pkg::DATA_W-1:0]  rd_value,
  output logic                        illegal
);
  import amo_pkg::*;

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata;

  logic [FUNC_W-1:0] func_q;
  logic [IDX_W-1:0]  idx_q;
  logic [DATA_W-1:0] operand_q;
  logic [REG_W-1:0]  dest_q;

  logic              res_valid;
  logic [IDX_W-1:0]  res_addr;

  logic [DATA_W-1:0] newv;
  logic [DATA_W-1:0] rd;
  logic              wr;
  logic              bad;
  logic              res_set;
  logic              res_clr;
  logic              sc_hit;

  assign sc_hit = res_valid && (res_addr == idx_q);

  always_comb begin
    newv    = rdata;
    rd      = rdata;
    wr      = 1'b1;
    bad     = 1'b0;
    res_set = 1'b0;
    res_clr = 1'b0;
    unique case (func_q)
      OP_LR: begin
        wr      = 1'b0;
        res_set = 1'b1;
      end
      OP_SC: begin
        if (sc_hit) begin
          newv    = operand_q;
          res_clr = 1'b1;
          rd      = '0;
        end else begin
          wr = 1'b0;
          rd = DATA_W'(1);
        end
      end
      OP_SWAP: newv = operand_q;
      OP_ADD:  newv = rdata + operand_q;
      OP_XOR:  newv = rdata ^ operand_q;
      OP_AND:  newv = rdata & operand_q;
      OP_OR:   newv = rdata | operand_q;
      OP_MIN:  newv = ($signed(operand_q) < $signed(rdata)) ? operand_q : rdata;
      OP_MAX:  newv = ($signed(rdata) < $signed(operand_q)) ? operand_q : rdata;
      OP_MINU: newv = (operand_q < rdata) ? operand_q : rdata;
      OP_MAXU: newv = (operand_q > rdata) ? operand_q : rdata;
      default: begin
        wr  = 1'b0;
        bad = 1'b1;
        rd  = '0;
      end
    endcase
  end

  // single write port shared by clearing pass and write-back; registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_we) begin
      mem[cmd.clear_idx] <= '0;
    end else if (cmd.exec && wr) begin
      mem[idx_q] <= newv;
    end
    if (cmd.accept) rdata <= mem[to_idx(address)];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q    <= func;
      idx_q     <= to_idx(address);
      operand_q <= operand;
      dest_q    <= dest_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_addr  <= '0;
    end else if (cmd.exec) begin
      if (res_set) begin
        res_valid <= 1'b1;
        res_addr  <= idx_q;
      end else if (res_clr) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      dest_out <= dest_q;
      rd_value <= rd;
      illegal  <= bad;
    end
  end

  assign sts.out_free = !out_valid || !out_stall;

endmodule

>>> sv/atomic_memory_op_unit.sv
// Atomic memory operation unit: each item is first accepted, which captures
// the word and reads the single-port store (registered read), then executed,
// which computes, writes back and loads the result register; in_stall stays
// high while it executes; a result waiting on out_stall holds execute. After
// reset a clearing pass zeroes all WORDS (1024) words, one word a cycle, with
// in_stall high. Addresses wrap modulo WORDS; one reservation is kept for lr/sc.
`timescale 1ns / 1ps

module atomic_memory_op_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [amo_pkg::FUNC_W-1:0]  func,
  input  logic [amo_pkg::ADDR_W-1:0]  address,
  input  logic [amo_pkg::DATA_W-1:0]  operand,
  input  logic [amo_pkg::REG_W-1:0]   dest_reg,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [amo_pkg::REG_W-1:0]   dest_out,
  output logic [amo_pkg::DATA_W-1:0]  rd_value,
  output logic                        illegal
);
  import amo_pkg::*;

  amo_cmd_t cmd;
  amo_sts_t sts;

  amo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  amo_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .address   (address),
    .operand   (operand),
    .dest_reg  (dest_reg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dest_out  (dest_out),
    .rd_value  (rd_value),
    .illegal   (illegal)
  );

endmodule

>>> sv/amo_checker.sv
// Port-level checks for atomic_memory_op_unit, bound to the top level.
// Depends on amo_pkg for field widths.
`timescale 1ns / 1ps

module amo_port_checks (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [amo_pkg::REG_W-1:0]   dest_out,
  input logic [amo_pkg::DATA_W-1:0]  rd_value,
  input logic                        illegal
);
  import amo_pkg::*;

  // one word in flight: stall rises right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a word while one is in flight");

  // illegal result returns zero
  a_illegal_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && illegal |-> rd_value == '0)
    else $error("illegal result with nonzero rd_value");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(rd_value) && $stable(dest_out)
      && $stable(illegal))
    else $error("stalled result changed");

  // nothing comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid && in_stall)
    else $error("activity right after reset");

endmodule

bind atomic_memory_op_unit amo_port_checks u_amo_port_checks (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .dest_out  (dest_out),
  .rd_value  (rd_value),
  .illegal   (illegal)
);

>>> dv/amo_checker.sv
// Checker for the atomic memory operation unit: watches both channels, predicts
// each result word from a shadow store and reservation, compares in order.
// Depends on amo_pkg for widths, store depth and operation codes.
`timescale 1ns / 1ps

module amo_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [amo_pkg::FUNC_W-1:0] func,
  input  logic [amo_pkg::ADDR_W-1:0] address,
  input  logic [amo_pkg::DATA_W-1:0] operand,
  input  logic [amo_pkg::REG_W-1:0]  dest_reg,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [amo_pkg::REG_W-1:0]  dest_out,
  input  logic [amo_pkg::DATA_W-1:0] rd_value,
  input  logic                       illegal,
  output int                         fail_count,
  output int                         pending
);
  import amo_pkg::*;

  typedef struct packed {
    logic [REG_W-1:0]  dest;
    logic [DATA_W-1:0] rd;
    logic              bad;
  } amo_result_t;

  amo_result_t       expected_results[$];
  logic [DATA_W-1:0] shadow_mem [WORDS];
  logic [IDX_W-1:0]  shadow_resv_idx;
  logic              shadow_resv_valid;
  int                errors;

  // Applies one operation to the shadow state and returns the word it answers with.
  function automatic amo_result_t amo_execute(input logic [FUNC_W-1:0] f,
                                              input logic [ADDR_W-1:0] a,
                                              input logic [DATA_W-1:0] src,
                                              input logic [REG_W-1:0]  d);
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] old_word;
    logic [DATA_W-1:0] new_word;
    logic              do_write;
    amo_result_t       r;
    idx      = IDX_W'(a % WORDS);
    old_word = shadow_mem[idx];
    new_word = old_word;
    do_write = 1'b1;
    r.dest   = d;
    r.rd     = old_word;
    r.bad    = 1'b0;
    case (f)
      OP_LR: begin
        do_write          = 1'b0;
        shadow_resv_idx   = idx;
        shadow_resv_valid = 1'b1;
      end
      OP_SC: begin
        if (shadow_resv_valid && shadow_resv_idx == idx) begin
          new_word          = src;
          shadow_resv_valid = 1'b0;
          r.rd              = '0;
        end else begin
          do_write = 1'b0;
          r.rd     = DATA_W'(1);
        end
      end
      OP_SWAP: new_word = src;
      OP_ADD:  new_word = old_word + src;
      OP_XOR:  new_word = old_word ^ src;
      OP_AND:  new_word = old_word & src;
      OP_OR:   new_word = old_word | src;
      OP_MIN:  new_word = ($signed(src) < $signed(old_word)) ? src : old_word;
      OP_MAX:  new_word = ($signed(old_word) < $signed(src)) ? src : old_word;
      OP_MINU: new_word = (src < old_word) ? src : old_word;
      OP_MAXU: new_word = (src > old_word) ? src : old_word;
      default: begin
        do_write = 1'b0;
        r.rd     = '0;
        r.bad    = 1'b1;
      end
    endcase
    if (do_write) shadow_mem[idx] = new_word;
    return r;
  endfunction

  always @(posedge clk) begin
    amo_result_t e;
    if (rst) begin
      for (int i = 0; i < WORDS; i++) shadow_mem[i] = '0;
      shadow_resv_idx   = '0;
      shadow_resv_valid = 1'b0;
      expected_results.delete();
      errors = 0;
    end else begin
      // results before new inputs: an input accepted now cannot answer this edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: dest_out %0d rd_value %h illegal %b",
                 dest_out, rd_value, illegal);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (dest_out !== e.dest) begin
            $error("dest_out mismatch: expected %0d, actual %0d", e.dest, dest_out);
            errors++;
          end
          if (rd_value !== e.rd) begin
            $error("rd_value mismatch: expected %h, actual %h", e.rd, rd_value);
            errors++;
          end
          if (illegal !== e.bad) begin
            $error("illegal mismatch: expected %b, actual %b", e.bad, illegal);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(amo_execute(func, address, operand, dest_reg));
    end
    fail_count <= errors;
    pending    <= expected_results.size();
  end

endmodule

>>> dv/tb_atomic_memory_op_unit.sv
// Top of the atomic memory operation unit testbench: clock, reset, stimulus,
// result-side stalls and verdict. Instantiates the block and amo_checker.
// Depends on amo_pkg, atomic_memory_op_unit and amo_checker.
`timescale 1ns / 1ps

module tb_atomic_memory_op_unit;
  import amo_pkg::*;

  localparam int RANDOM_ITEMS   = 1650;
  localparam int MAX_GAP        = 13;
  localparam int HOLD_OFF       = 300;  // long result-side stall, once
  localparam int HOLD_OFF_AFTER = 500;
  localparam int IDLE_LIMIT     = 5000; // covers the clearing pass after reset
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [FUNC_W-1:0] FUNC_BAD_LO = OP_MAXU + 1'b1;
  localparam logic [FUNC_W-1:0] FUNC_BAD_HI = '1;
  localparam logic [ADDR_W-1:0] ADDR_TOP    = ADDR_W'(WORDS - 1);
  localparam logic [DATA_W-1:0] ALL_ONES    = '1;
  localparam logic [DATA_W-1:0] SIGN_ONLY   = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX_POS     = {1'b0, {(DATA_W-1){1'b1}}};

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] operand;
  logic [REG_W-1:0]  dest_reg;
  logic              out_valid;
  logic              out_stall;
  logic [REG_W-1:0]  dest_out;
  logic [DATA_W-1:0] rd_value;
  logic              illegal;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int random_sent = 0;
  bit send_burst  = 1'b0;

  atomic_memory_op_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .address  (address),
    .operand  (operand),
    .dest_reg (dest_reg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dest_out (dest_out),
    .rd_value (rd_value),
    .illegal  (illegal)
  );

  amo_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .address   (address),
    .operand   (operand),
    .dest_reg  (dest_reg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dest_out  (dest_out),
    .rd_value  (rd_value),
    .illegal   (illegal),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offers one word after a random gap, or none in a burst, and returns on the edge that takes it.
  task automatic send_word(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                           input logic [DATA_W-1:0] src, input logic [REG_W-1:0] d);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    address  <= a;
    operand  <= src;
    dest_reg <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // Mostly a handful of hot words so that operations chain on live data.
  function automatic logic [ADDR_W-1:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      if (r == 0) return ADDR_TOP;
      return ADDR_W'(r - 1);
    end
    return ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return SIGN_ONLY;
      3:       return MAX_POS;
      4:       return DATA_W'($urandom_range(0, 15));
      5:       return -DATA_W'($urandom_range(1, 15));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] pick_rmw();
    return FUNC_W'($urandom_range(OP_SWAP, OP_MAXU));
  endfunction

  function automatic logic [REG_W-1:0] pick_dest();
    return REG_W'($urandom_range(0, (1 << REG_W) - 1));
  endfunction

  task automatic send_random(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a);
    send_word(f, a, pick_operand(), pick_dest());
    random_sent++;
    if (random_sent % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
  endtask

  // Main stimulus: directed corners, then lr/sc sequences, rmw traffic and noise.
  initial begin
    logic [ADDR_W-1:0] resv_addr;
    int r;
    int between;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    func     <= OP_LR;
    address  <= '0;
    operand  <= '0;
    dest_reg <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // lr/sc basics: success, repeat fails, wrong address fails
    send_word(OP_LR, '0, '0, '0);
    send_word(OP_SC, '0, ALL_ONES, 5'd31);
    send_word(OP_SC, '0, '0, 5'd1);
    send_word(OP_LR, ADDR_TOP, ALL_ONES, 5'd2);
    send_word(OP_SC, ADDR_W'(1), ALL_ONES, 5'd3);
    send_word(OP_SC, ADDR_TOP, SIGN_ONLY, 5'd4);
    // every rmw operation on extreme words; add wraps
    send_word(OP_SWAP, ADDR_TOP, DATA_W'(1), 5'd5);
    send_word(OP_ADD, '0, DATA_W'(1), 5'd6);
    send_word(OP_XOR, '0, ALL_ONES, 5'd7);
    send_word(OP_AND, '0, {(DATA_W/8){8'h0f}}, 5'd8);
    send_word(OP_OR, '0, {(DATA_W/8){8'hf0}}, 5'd9);
    send_word(OP_MIN, ADDR_TOP, ALL_ONES, 5'd10);
    send_word(OP_MAX, ADDR_TOP, MAX_POS, 5'd11);
    send_word(OP_MINU, ADDR_TOP, SIGN_ONLY, 5'd12);
    send_word(OP_MAXU, ADDR_TOP, SIGN_ONLY, 5'd13);
    send_word(FUNC_BAD_LO, '0, ALL_ONES, 5'd31);
    // illegal and rmw leave the reservation alone; a second lr moves it
    send_word(OP_LR, ADDR_W'(5), '0, 5'd14);
    send_word(FUNC_BAD_HI, ADDR_W'(5), ALL_ONES, 5'd15);
    send_word(OP_SC, ADDR_W'(5), MAX_POS, 5'd16);
    send_word(OP_LR, ADDR_W'(7), '0, 5'd17);
    send_word(OP_SWAP, ADDR_W'(7), SIGN_ONLY, 5'd18);
    send_word(OP_SC, ADDR_W'(7), DATA_W'(3), 5'd19);
    send_word(OP_LR, ADDR_W'(3), '0, 5'd20);
    send_word(OP_LR, ADDR_W'(4), '0, 5'd21);
    send_word(OP_SC, ADDR_W'(3), ALL_ONES, 5'd0);

    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        resv_addr = pick_addr();
        send_random(OP_LR, resv_addr);
        between = $urandom_range(0, 2);
        repeat (between) begin
          if ($urandom_range(0, 5) == 0)
            send_random(FUNC_W'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI)), pick_addr());
          else
            send_random(pick_rmw(), pick_addr());
        end
        send_random(OP_SC, ($urandom_range(0, 3) != 0) ? resv_addr : pick_addr());
      end else if (r < 85) begin
        send_random(pick_rmw(), pick_addr());
      end else if (r < 93) begin
        send_random(($urandom_range(0, 1) != 0) ? OP_SC : OP_LR, pick_addr());
      end else begin
        send_random(FUNC_W'($urandom_range(FUNC_BAD_LO, FUNC_BAD_HI)), pick_addr());
      end
    end
    in_valid <= 1'b0;

    // let the checker count the last accepted word before polling
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: random stall before each word, burst stretches, one long hold-off.
  initial begin
    int k;
    int taken;
    bit recv_burst;
    bit held;
    taken      = 0;
    recv_burst = 1'b0;
    held       = 1'b0;
    out_stall <= 1'b1;
    @(negedge rst);
    forever begin
      if (!held && taken >= HOLD_OFF_AFTER) begin
        k    = HOLD_OFF;
        held = 1'b1;
      end else begin
        k = recv_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      if (taken % 80 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
